### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the RTL folder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### hw/rtl/llcsh_pkg.sv
// Package for the login line capture block: stream codes, character constants,
// the line-mode table and the prompt text. Depends on nothing.
package llcsh_pkg;

   typedef logic [3:0] entry_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_MODE = 2'd1,
      KIND_NAME = 2'd2,
      KIND_DONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [6:0] pad;
      logic       cr_seen;
      logic       lcase_on;
      logic       slow_line;
      logic [1:0] speed;
      entry_type  entry;
      logic [7:0] byte_out;
   } rsp_data_type;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_CHAR  = 1'b1;

   localparam logic [6:0] CH_NUL = 7'h00;
   localparam logic [6:0] CH_BS  = 7'h08;
   localparam logic [6:0] CH_LF  = 7'h0A;
   localparam logic [6:0] CH_CR  = 7'h0D;
   localparam logic [6:0] CH_NAK = 7'h15;
   localparam logic [6:0] CH_SP  = 7'h20;
   localparam logic [6:0] CH_LC_A = 7'h61;
   localparam logic [6:0] CH_LC_Z = 7'h7A;
   localparam logic [6:0] CH_UC_A = 7'h41;
   localparam logic [6:0] CH_UC_Z = 7'h5A;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   localparam entry_type LAST_ENTRY  = 4'd9;
   localparam logic [3:0] PROMPT_LAST = 4'd8;

   function automatic logic [7:0] tab_code(input entry_type e);
      case (e)
         4'd0:    tab_code = 8'h2D;
         4'd1:    tab_code = 8'h30;
         4'd2:    tab_code = 8'h01;
         4'd3:    tab_code = 8'h02;
         4'd4:    tab_code = 8'h31;
         4'd5:    tab_code = 8'h03;
         4'd6:    tab_code = 8'h04;
         4'd7:    tab_code = 8'h05;
         4'd8:    tab_code = 8'h32;
         4'd9:    tab_code = 8'h06;
         default: tab_code = 8'h2D;
      endcase
   endfunction

   function automatic entry_type tab_next(input entry_type e);
      case (e)
         4'd0:    tab_next = 4'd0;
         4'd1:    tab_next = 4'd2;
         4'd2:    tab_next = 4'd3;
         4'd3:    tab_next = 4'd1;
         4'd4:    tab_next = 4'd5;
         4'd5:    tab_next = 4'd6;
         4'd6:    tab_next = 4'd7;
         4'd7:    tab_next = 4'd4;
         4'd8:    tab_next = 4'd9;
         4'd9:    tab_next = 4'd8;
         default: tab_next = 4'd0;
      endcase
   endfunction

   function automatic logic [1:0] tab_speed(input entry_type e);
      case (e)
         4'd0, 4'd4:       tab_speed = 2'd3;
         4'd1, 4'd5, 4'd8: tab_speed = 2'd2;
         4'd2, 4'd6, 4'd9: tab_speed = 2'd1;
         4'd3, 4'd7:       tab_speed = 2'd0;
         default:          tab_speed = 2'd3;
      endcase
   endfunction

   // the 110 baud teletype entries use delays and default to upper case
   function automatic logic tab_teletype(input entry_type e);
      case (e)
         4'd3, 4'd7: tab_teletype = 1'b1;
         default:    tab_teletype = 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] prompt_char(input logic [3:0] idx);
      case (idx)
         4'd0:    prompt_char = 8'h0D;
         4'd1:    prompt_char = 8'h0A;
         4'd2:    prompt_char = 8'h6C;
         4'd3:    prompt_char = 8'h6F;
         4'd4:    prompt_char = 8'h67;
         4'd5:    prompt_char = 8'h69;
         4'd6:    prompt_char = 8'h6E;
         4'd7:    prompt_char = 8'h3A;
         4'd8:    prompt_char = 8'h20;
         default: prompt_char = 8'h20;
      endcase
   endfunction

endpackage

### hw/rtl/login_line_capture_speed_hunt.sv
// Top level of the login line capture block: sequencer, name memory and result register.
// Depends on llcsh_pkg.
//
// A start request (tuser 0) searches the ten-entry line-mode table one entry a cycle with a
// single comparator, then sends the mode result and the nine prompt bytes.
// A character request (tuser 1) sends its first result in its decode cycle: an echo is
// 1 result, an erase 3, a line kill 1 plus 3 per stored character, a completed line the
// echo, the line-end byte, one result per name character and the done result, the name
// read in order from the name memory, which has one write and one read port. A break sends
// nothing in its decode cycle, then the mode result and the prompt. Results leave through
// one output register at one per cycle while rsp_tready stays high; req_tready is high
// only between requests, so a new request waits until the last is through. A character
// request is ignored outside line collection; an erase on an empty line sends nothing.
module login_line_capture_speed_hunt #(
   parameter int NAME_MAX = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // [7:0] byte_in
   input  logic                     req_tuser,  // [0] action
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output llcsh_pkg::rsp_data_type  rsp_tdata,  // [7:0] byte_out, [11:8] entry,
                                                // [13:12] speed, [14] slow_line,
                                                // [15] lcase_on, [16] cr_seen, zeros above
   output llcsh_pkg::kind_type      rsp_tuser,  // [1:0] kind
   output logic                     rsp_tlast
);
   import llcsh_pkg::*;

   localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int FW = $clog2(NAME_MAX + 1);
   localparam int CW = $clog2(NAME_MAX + 2);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOKUP, S_MODE, S_PROMPT, S_CHAR, S_ERASE_SP,
      S_ERASE_BS, S_KILL, S_FINISH, S_NAME, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_COLLECT, PH_DONE
   } phase_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   entry_type     entry_ff, entry_in;
   logic [7:0]    byte_ff, byte_in;
   logic [3:0]    step_ff, step_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] nidx_ff, nidx_in;
   logic [CW-1:0] upper_ff, upper_in;
   logic [CW-1:0] lower_ff, lower_in;
   logic          by_cr_ff, by_cr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;
   kind_type      rsp_kind_ff, rsp_kind_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    name_mem [NAME_MAX];
   logic [7:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   logic          out_free, emit_go, em_lcase, em_cr, em_last;
   kind_type      em_kind;
   logic [7:0]    em_byte;
   logic [6:0]    ch, folded;
   logic          is_lower, is_upper, is_full, rd_lower, lcase_final;
   logic [FW-1:0] fill_dec, nidx_inc;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign ch          = byte_ff[6:0];
   assign is_lower    = (ch >= CH_LC_A) && (ch <= CH_LC_Z);
   assign is_upper    = (ch >= CH_UC_A) && (ch <= CH_UC_Z);
   assign folded      = is_upper ? ch + CASE_OFFSET : ch;
   assign is_full     = fill_ff == FW'(NAME_MAX);
   assign fill_dec    = fill_ff - 1'b1;
   assign nidx_inc    = nidx_ff + 1'b1;
   assign rd_lower    = (rd_data_ff[6:0] >= CH_LC_A) && (rd_data_ff[6:0] <= CH_LC_Z);
   assign lcase_final = (lower_ff != '0) ? 1'b0 :
                        (upper_ff != '0) ? 1'b1 : tab_teletype(entry_ff);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      entry_in  = entry_ff;
      byte_in   = byte_ff;
      step_in   = step_ff;
      fill_in   = fill_ff;
      nidx_in   = nidx_ff;
      upper_in  = upper_ff;
      lower_in  = lower_ff;
      by_cr_in  = by_cr_ff;
      emit_go   = 1'b0;
      em_kind   = KIND_BYTE;
      em_byte   = 8'h00;
      em_lcase  = 1'b0;
      em_cr     = 1'b0;
      em_last   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = fill_ff[AW-1:0];
      mem_wdata = {is_upper, folded};
      mem_re    = 1'b0;
      mem_raddr = fill_dec[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               if (req_tuser == ACT_START) begin
                  step_in  = 4'd0;
                  state_in = S_LOOKUP;
               end else if (phase_ff == PH_COLLECT) begin
                  state_in = S_CHAR;
               end
            end
         end
         S_LOOKUP: begin
            if (tab_code(step_ff) == byte_ff) begin
               entry_in = step_ff;
               state_in = S_MODE;
            end else if (step_ff == LAST_ENTRY) begin
               entry_in = '0;
               state_in = S_MODE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MODE: begin
            if (out_free) begin
               emit_go  = 1'b1;
               em_kind  = KIND_MODE;
               fill_in  = '0;
               upper_in = '0;
               lower_in = '0;
               phase_in = PH_COLLECT;
               step_in  = 4'd0;
               state_in = S_PROMPT;
            end
         end
         S_PROMPT: begin
            if (out_free) begin
               emit_go = 1'b1;
               em_byte = prompt_char(step_ff);
               em_last = step_ff == PROMPT_LAST;
               step_in = step_ff + 1'b1;
               if (step_ff == PROMPT_LAST) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CHAR: begin
            if (ch == CH_NUL) begin
               entry_in = tab_next(entry_ff);
               state_in = S_MODE;
            end else if (ch == CH_BS && fill_ff == '0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit_go = 1'b1;
               em_byte = byte_ff;
               if (ch == CH_BS) begin
                  mem_re   = 1'b1;
                  state_in = S_ERASE_SP;
               end else if (ch == CH_NAK) begin
                  upper_in = '0;
                  lower_in = '0;
                  step_in  = 4'd0;
                  if (fill_ff == '0) begin
                     em_last  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_KILL;
                  end
               end else begin
                  if (is_lower) begin
                     lower_in = lower_ff + 1'b1;
                  end
                  if (is_upper) begin
                     upper_in = upper_ff + 1'b1;
                  end
                  if (ch == CH_CR) begin
                     by_cr_in = 1'b1;
                     state_in = S_FINISH;
                  end else if (ch == CH_LF || is_full) begin
                     by_cr_in = 1'b0;
                     state_in = S_FINISH;
                  end else begin
                     mem_we   = 1'b1;
                     fill_in  = fill_ff + 1'b1;
                     em_last  = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_ERASE_SP: begin
            if (out_free) begin
               emit_go  = 1'b1;
               em_byte  = {1'b0, CH_SP};
               state_in = S_ERASE_BS;
            end
         end
         S_ERASE_BS: begin
            if (out_free) begin
               emit_go = 1'b1;
               em_byte = {1'b0, CH_BS};
               em_last = 1'b1;
               fill_in = fill_dec;
               if (rd_data_ff[7]) begin
                  if (upper_ff != '0) begin
                     upper_in = upper_ff - 1'b1;
                  end
               end else if (rd_lower && lower_ff != '0) begin
                  lower_in = lower_ff - 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_KILL: begin
            if (out_free) begin
               emit_go = 1'b1;
               em_byte = (step_ff == 4'd1) ? {1'b0, CH_SP} : {1'b0, CH_BS};
               if (step_ff == 4'd2) begin
                  step_in = 4'd0;
                  fill_in = fill_dec;
                  if (fill_dec == '0) begin
                     em_last  = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               emit_go   = 1'b1;
               em_byte   = by_cr_ff ? {1'b0, CH_LF} : {1'b0, CH_CR};
               nidx_in   = '0;
               mem_raddr = '0;
               if (fill_ff != '0) begin
                  mem_re   = 1'b1;
                  state_in = S_NAME;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_NAME: begin
            if (out_free) begin
               emit_go   = 1'b1;
               em_kind   = KIND_NAME;
               em_byte   = {1'b0, rd_data_ff[6:0]};
               nidx_in   = nidx_inc;
               mem_raddr = nidx_inc[AW-1:0];
               if (nidx_inc < fill_ff) begin
                  mem_re = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit_go  = 1'b1;
               em_kind  = KIND_DONE;
               em_lcase = lcase_final;
               em_cr    = by_cr_ff;
               em_last  = 1'b1;
               phase_in = PH_DONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in          = 1'b1;
         rsp_kind_in           = em_kind;
         rsp_last_in           = em_last;
         rsp_data_in.pad       = '0;
         rsp_data_in.cr_seen   = em_cr;
         rsp_data_in.lcase_on  = em_lcase;
         rsp_data_in.slow_line = tab_teletype(entry_ff);
         rsp_data_in.speed     = tab_speed(entry_ff);
         rsp_data_in.entry     = entry_ff;
         rsp_data_in.byte_out  = em_byte;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         entry_ff     <= '0;
         step_ff      <= '0;
         fill_ff      <= '0;
         nidx_ff      <= '0;
         upper_ff     <= '0;
         lower_ff     <= '0;
         by_cr_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         entry_ff     <= entry_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         nidx_ff      <= nidx_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         by_cr_ff     <= by_cr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= name_mem[mem_raddr];
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hw/rtl/llcsh_chk.sv
// Port checker for the login line capture block, bound to the top level below.
// Depends on llcsh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llcsh_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,  // [7:0] byte_in
   input logic        req_tuser,  // [0] action
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,  // [7:0] byte_out, [11:8] entry, [13:12] speed,
                                  // [14] slow_line, [15] lcase_on, [16] cr_seen
   input logic [1:0]  rsp_tuser,  // [1:0] kind
   input logic        rsp_tlast
);
   import llcsh_pkg::*;

   logic start_taken;
   logic rsp_stall;

   assign start_taken = req_tvalid && req_tready && req_tuser == ACT_START;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;

   `CHK_NEXT(a_start_busy, clock, reset, start_taken, !req_tready)
   `CHK_SAME(a_done_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_DONE, rsp_tlast)
   `CHK_SAME(a_mode_not_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_MODE, !rsp_tlast)
   `CHK_SAME(a_entry_range, clock, reset, rsp_tvalid, rsp_tdata[11:8] <= LAST_ENTRY)
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind login_line_capture_speed_hunt llcsh_chk u_llcsh_chk (.*);
